>>> hw/rtl/wps_pkg.sv
// ----------------------------------------------------------------------------
// wps_pkg
// Shared types and constants of the watering pump sequencer: state and
// opcode codes, register indexes, field widths and the transaction structs.
// ----------------------------------------------------------------------------
package wps_pkg;

  localparam int OP_W    = 2;
  localparam int NOW_W   = 32;
  localparam int MOIST_W = 10;
  localparam int VOL_W   = 16;
  localparam int CNT_W   = 4;
  localparam int TOT_W   = 32;
  localparam int ST_W    = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [ST_W-1:0] ST_IDLE  = 2'd0;
  localparam logic [ST_W-1:0] ST_CHECK = 2'd1;
  localparam logic [ST_W-1:0] ST_WATER = 2'd2;
  localparam logic [ST_W-1:0] ST_COOL  = 2'd3;

  localparam logic [OP_W-1:0] OP_TICK = 2'd0;
  localparam logic [OP_W-1:0] OP_ON   = 2'd1;
  localparam logic [OP_W-1:0] OP_OFF  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_MOISTURE_THRESHOLD  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COOLDOWN_TIME_MS    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_CYCLES_PER_HOUR = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET_VOLUME_ML    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_PUMP_TIMEOUT_MS     = 3'd4;

  localparam logic [31:0] HOUR_MS = 32'd3600000;
  localparam logic [31:0] DAY_MS  = 32'd86400000;
  localparam logic [31:0] WEEK_MS = 32'd604800000;

  localparam logic [MOIST_W-1:0] RST_MOISTURE_THRESHOLD  = 10'd300;
  localparam logic [31:0]        RST_COOLDOWN_TIME_MS    = 32'd1800000;
  localparam logic [CNT_W-1:0]   RST_MAX_CYCLES_PER_HOUR = 4'd3;
  localparam logic [VOL_W-1:0]   RST_TARGET_VOLUME_ML    = 16'd500;
  localparam logic [31:0]        RST_PUMP_TIMEOUT_MS     = 32'd60000;

  typedef struct packed {
    logic [MOIST_W-1:0] moisture_threshold;
    logic [31:0]        cooldown_time_ms;
    logic [CNT_W-1:0]   max_cycles_per_hour;
    logic [VOL_W-1:0]   target_volume_ml;
    logic [31:0]        pump_timeout_ms;
  } cfg_t;

  typedef struct packed {
    logic [OP_W-1:0]    opcode;
    logic [NOW_W-1:0]   now_ms;
    logic               moisture_valid;
    logic [MOIST_W-1:0] moisture_tenths;
    logic [VOL_W-1:0]   cycle_volume_ml;
    logic               rain_expected;
  } item_t;

  typedef struct packed {
    logic [ST_W-1:0]  state_code;
    logic             pump_on;
    logic             clear_flow_counter;
    logic             cycle_finished;
    logic [CNT_W-1:0] cycles_this_hour;
    logic [TOT_W-1:0] volume_today_ml;
    logic [TOT_W-1:0] volume_week_ml;
    logic             override_active;
  } result_t;

endpackage

>>> hw/rtl/wps_core.sv
// ----------------------------------------------------------------------------
// wps_core
// Sequencer state and next-state logic. Forms the result of one transaction
// combinationally and commits the new state when step is high.
// ----------------------------------------------------------------------------
module wps_core #(
  parameter int TIME_BITS = 32
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             step,
  input  wps_pkg::cfg_t    cfg,
  input  wps_pkg::item_t   item,
  output wps_pkg::result_t res
);

  localparam int CMP_W = (TIME_BITS > 32) ? TIME_BITS : 32;
  localparam logic [CMP_W-1:0] HOUR_C = CMP_W'(wps_pkg::HOUR_MS);
  localparam logic [CMP_W-1:0] DAY_C  = CMP_W'(wps_pkg::DAY_MS);
  localparam logic [CMP_W-1:0] WEEK_C = CMP_W'(wps_pkg::WEEK_MS);

  typedef logic [TIME_BITS-1:0] tm_t;

  function automatic logic [CMP_W-1:0] since(tm_t a, tm_t b);
    tm_t d;
    d = a - b;
    return CMP_W'(d);
  endfunction

  function automatic logic [wps_pkg::TOT_W-1:0] sat_add(
    logic [wps_pkg::TOT_W-1:0] a, logic [wps_pkg::VOL_W-1:0] b);
    logic [wps_pkg::TOT_W:0] s;
    s = {1'b0, a} + (wps_pkg::TOT_W+1)'(b);
    return s[wps_pkg::TOT_W] ? '1 : s[wps_pkg::TOT_W-1:0];
  endfunction

  logic [wps_pkg::ST_W-1:0]  st, st_next;
  logic                      ovr, ovr_next;
  logic                      cdv, cdv_next;
  tm_t                       pst, pst_next;
  tm_t                       cst, cst_next;
  tm_t                       hws, hws_next;
  logic [wps_pkg::CNT_W-1:0] hcc, hcc_next;
  logic [wps_pkg::TOT_W-1:0] dtot, dtot_next;
  logic [wps_pkg::TOT_W-1:0] wtot, wtot_next;
  tm_t                       dws, dws_next;
  tm_t                       wws, wws_next;

  tm_t                       now;
  logic                      hour_roll, day_roll, week_roll;
  logic                      cool_wait, water_stop;
  logic [wps_pkg::CNT_W-1:0] hcc_base;
  logic [wps_pkg::TOT_W-1:0] dsum, wsum;
  logic                      start, finish, tick, clr;

  assign now        = tm_t'(item.now_ms);
  assign hour_roll  = since(now, hws) >= HOUR_C;
  assign day_roll   = since(now, dws) >= DAY_C;
  assign week_roll  = since(now, wws) >= WEEK_C;
  assign cool_wait  = since(now, cst) < CMP_W'(cfg.cooldown_time_ms);
  assign water_stop = (item.cycle_volume_ml >= cfg.target_volume_ml) ||
                      (since(now, pst) >= CMP_W'(cfg.pump_timeout_ms));
  assign hcc_base   = hour_roll ? '0 : hcc;
  assign dsum       = sat_add(dtot, item.cycle_volume_ml);
  assign wsum       = sat_add(wtot, item.cycle_volume_ml);

  always_comb begin
    st_next   = st;
    ovr_next  = ovr;
    cdv_next  = cdv;
    pst_next  = pst;
    cst_next  = cst;
    hws_next  = hour_roll ? now : hws;
    hcc_next  = hcc_base;
    dtot_next = dtot;
    wtot_next = wtot;
    dws_next  = dws;
    wws_next  = wws;
    start     = 1'b0;
    finish    = 1'b0;
    tick      = 1'b0;
    clr       = 1'b0;

    case (item.opcode)
      wps_pkg::OP_ON: begin
        ovr_next = 1'b1;
        start    = (st == wps_pkg::ST_IDLE);
      end
      wps_pkg::OP_OFF: begin
        ovr_next = 1'b0;
        finish   = (st == wps_pkg::ST_WATER);
      end
      default: begin
        tick = 1'b1;
        unique case (st)
          wps_pkg::ST_IDLE: begin
            if (ovr) begin
              start = 1'b1;
            end else if (item.moisture_valid &&
                         item.moisture_tenths < cfg.moisture_threshold) begin
              st_next = wps_pkg::ST_CHECK;
            end
          end
          wps_pkg::ST_CHECK: begin
            if (cdv && cool_wait) begin
              st_next = wps_pkg::ST_IDLE;
            end else if (hcc_base >= cfg.max_cycles_per_hour || item.rain_expected) begin
              st_next = wps_pkg::ST_IDLE;
            end else begin
              start    = 1'b1;
              hcc_next = hcc_base + 4'd1;
            end
          end
          wps_pkg::ST_WATER: begin
            finish = water_stop;
          end
          wps_pkg::ST_COOL: begin
            if (!cool_wait) begin
              st_next = wps_pkg::ST_IDLE;
            end
          end
          default: begin
            st_next = st;
          end
        endcase
      end
    endcase

    if (start) begin
      st_next  = wps_pkg::ST_WATER;
      pst_next = now;
      clr      = 1'b1;
    end
    if (finish) begin
      ovr_next  = 1'b0;
      dtot_next = dsum;
      wtot_next = wsum;
      st_next   = wps_pkg::ST_COOL;
      cst_next  = now;
      cdv_next  = 1'b1;
    end
    // rollover on ticks, after the state logic, so volume added in the same tick is cleared
    if (tick && day_roll) begin
      dtot_next = '0;
      dws_next  = now;
    end
    if (tick && week_roll) begin
      wtot_next = '0;
      wws_next  = now;
    end
  end

  always_comb begin
    res.state_code         = st_next;
    res.pump_on            = (st_next == wps_pkg::ST_WATER);
    res.clear_flow_counter = clr;
    res.cycle_finished     = finish;
    res.cycles_this_hour   = hcc_next;
    res.volume_today_ml    = dtot_next;
    res.volume_week_ml     = wtot_next;
    res.override_active    = ovr_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st   <= wps_pkg::ST_IDLE;
      ovr  <= 1'b0;
      cdv  <= 1'b0;
      pst  <= '0;
      cst  <= '0;
      hws  <= '0;
      hcc  <= '0;
      dtot <= '0;
      wtot <= '0;
      dws  <= '0;
      wws  <= '0;
    end else if (step) begin
      st   <= st_next;
      ovr  <= ovr_next;
      cdv  <= cdv_next;
      pst  <= pst_next;
      cst  <= cst_next;
      hws  <= hws_next;
      hcc  <= hcc_next;
      dtot <= dtot_next;
      wtot <= wtot_next;
      dws  <= dws_next;
      wws  <= wws_next;
    end
  end

  a_clear_enters_water: assert property (@(posedge clk) disable iff (rst)
    step && res.clear_flow_counter |=> st == wps_pkg::ST_WATER && pst == $past(now))
    else $error("flow counter clear without watering start");

  a_finish_enters_cool: assert property (@(posedge clk) disable iff (rst)
    step && res.cycle_finished |=> st == wps_pkg::ST_COOL && cdv && !ovr)
    else $error("finished cycle did not enter cooldown");

  a_hold_without_step: assert property (@(posedge clk) disable iff (rst)
    !step |=> $stable(st) && $stable(dtot) && $stable(hcc))
    else $error("state moved without a transaction");

endmodule

>>> hw/rtl/watering_pump_sequencer.sv
// ----------------------------------------------------------------------------
// watering_pump_sequencer
// Four-state pump sequencer (idle, check, watering, cooldown) with manual
// override, per-hour cycle limit and saturating daily and weekly totals.
// ----------------------------------------------------------------------------
// Each input transaction (tick, manual on, manual off) yields exactly one
// result transaction. A transaction is registered on input, evaluated
// combinationally by the next-state logic and registered on output, so one
// transaction is taken every clock cycle as long as the output is not stalled;
// the input register can take one new transaction while the previous result
// waits on the output. Registers are written through the cfg
// channel, which is always ready. TIME_BITS sets the width of the internal
// time stamps; all time differences wrap modulo 2^TIME_BITS.
module watering_pump_sequencer #(
  parameter int TIME_BITS = 32
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [wps_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [wps_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [wps_pkg::OP_W-1:0]         opcode,
  input  logic [wps_pkg::NOW_W-1:0]        now_ms,
  input  logic                             moisture_valid,
  input  logic [wps_pkg::MOIST_W-1:0]      moisture_tenths,
  input  logic [wps_pkg::VOL_W-1:0]        cycle_volume_ml,
  input  logic                             rain_expected,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [wps_pkg::ST_W-1:0]         state_code,
  output logic                             pump_on,
  output logic                             clear_flow_counter,
  output logic                             cycle_finished,
  output logic [wps_pkg::CNT_W-1:0]        cycles_this_hour,
  output logic [wps_pkg::TOT_W-1:0]        volume_today_ml,
  output logic [wps_pkg::TOT_W-1:0]        volume_week_ml,
  output logic                             override_active
);

  wps_pkg::cfg_t    cfg;
  wps_pkg::item_t   in_item;
  wps_pkg::item_t   s1_item;
  logic             s1_valid;
  logic             adv;
  wps_pkg::result_t res_next;
  wps_pkg::result_t res;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.moisture_threshold  <= wps_pkg::RST_MOISTURE_THRESHOLD;
      cfg.cooldown_time_ms    <= wps_pkg::RST_COOLDOWN_TIME_MS;
      cfg.max_cycles_per_hour <= wps_pkg::RST_MAX_CYCLES_PER_HOUR;
      cfg.target_volume_ml    <= wps_pkg::RST_TARGET_VOLUME_ML;
      cfg.pump_timeout_ms     <= wps_pkg::RST_PUMP_TIMEOUT_MS;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        wps_pkg::CFG_MOISTURE_THRESHOLD:
          cfg.moisture_threshold <= cfg_data[wps_pkg::MOIST_W-1:0];
        wps_pkg::CFG_COOLDOWN_TIME_MS:
          cfg.cooldown_time_ms <= cfg_data[31:0];
        wps_pkg::CFG_MAX_CYCLES_PER_HOUR:
          cfg.max_cycles_per_hour <= cfg_data[wps_pkg::CNT_W-1:0];
        wps_pkg::CFG_TARGET_VOLUME_ML:
          cfg.target_volume_ml <= cfg_data[wps_pkg::VOL_W-1:0];
        wps_pkg::CFG_PUMP_TIMEOUT_MS:
          cfg.pump_timeout_ms <= cfg_data[31:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    in_item.opcode          = opcode;
    in_item.now_ms          = now_ms;
    in_item.moisture_valid  = moisture_valid;
    in_item.moisture_tenths = moisture_tenths;
    in_item.cycle_volume_ml = cycle_volume_ml;
    in_item.rain_expected   = rain_expected;
  end

  assign adv      = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_item <= in_item;
    end
  end

  wps_core #(
    .TIME_BITS(TIME_BITS)
  ) u_core (
    .clk  (clk),
    .rst  (rst),
    .step (adv),
    .cfg  (cfg),
    .item (s1_item),
    .res  (res_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res <= res_next;
    end
  end

  assign state_code         = res.state_code;
  assign pump_on            = res.pump_on;
  assign clear_flow_counter = res.clear_flow_counter;
  assign cycle_finished     = res.cycle_finished;
  assign cycles_this_hour   = res.cycles_this_hour;
  assign volume_today_ml    = res.volume_today_ml;
  assign volume_week_ml     = res.volume_week_ml;
  assign override_active    = res.override_active;

  a_no_stall_when_drained: assert property (@(posedge clk) disable iff (rst)
    out_ready |-> in_ready)
    else $error("input stalled while output side is ready");

  a_step_fills_output: assert property (@(posedge clk) disable iff (rst)
    adv |=> out_valid)
    else $error("evaluated transaction not presented on output");

  a_accept_fills_stage: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> s1_valid)
    else $error("accepted transaction lost at input register");

endmodule
